// File: rtl/escaped_frame_receiver_xor_check_unit_defines.svh
// Assertion macros for the escaped frame receiver.
// No dependencies; included by the top level only.
`ifndef ESCAPED_FRAME_RECEIVER_XOR_CHECK_UNIT_DEFINES_SVH
`define ESCAPED_FRAME_RECEIVER_XOR_CHECK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define EFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define EFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define EFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define EFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/efr_pkg.sv
// Shared types and constants for the escaped frame receiver.
// No dependencies; imported by every module of the block.
package efr_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'hFF;
    localparam logic [7:0] ESC_BYTE  = 8'hFE;
    localparam logic [8:0] HDR_COUNT = 9'd2;

    localparam logic [0:0] CFG_CHECK_ENABLE = 1'b0;
    localparam logic [0:0] CFG_RAW_LIMIT    = 1'b1;

    localparam logic       CHECK_ENABLE_RST = 1'b1;
    localparam logic [7:0] RAW_LIMIT_RST    = 8'd255;

    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_OK       = 3'd1,
        KIND_BCC      = 3'd2,
        KIND_OVERFLOW = 3'd3,
        KIND_EMPTY    = 3'd4,
        KIND_DANGLING = 3'd5
    } t_kind;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] data;
    } t_result;

    typedef struct packed {
        logic       check_enable;
        logic [7:0] raw_length_limit;
    } t_cfg;

endpackage

// File: rtl/escaped_frame_receiver_xor_check_unit.sv
// Top level of the escaped frame receiver with XOR block check.
// Depends on efr_pkg, efr_core, efr_out_reg and the assertion macro header.
//
// Usage:
//   Input channel (i_valid / o_ready / i_rx_byte) takes one raw line byte per
//   beat. The block hunts for two 0xFF bytes, then unescapes the frame body
//   (0xFE escapes the next byte) and emits payload bytes one place late.
//   On a closing 0xFF or on overflow of raw_length_limit a status beat is
//   given instead: ok, checksum error, overflow, empty or dangling escape.
//   Output channel (o_valid / i_ready / o_result_kind / o_payload_byte).
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//   writes check_enable (index 0) or raw_length_limit (index 1); always ready.
// Timing:
//   A byte accepted into the input register is decoded there and its result,
//   if any, is loaded into the result register and shows on o_valid.
//   Throughput is one byte per cycle while results are taken: the decode is
//   a single pass between the input register and the result register.
// Reset: synchronous, active low; clears the frame state, both registers'
//   valid flags, and loads check_enable = 1, raw_length_limit = 255.
// Stall: while a result waits on i_ready, bytes that give no result still
//   advance; a byte that gives a result holds in the input register.
`include "escaped_frame_receiver_xor_check_unit_defines.svh"

module escaped_frame_receiver_xor_check_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_result_kind,
    output logic [7:0]           o_payload_byte,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [0:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data
);
    import efr_pkg::*;

    // configuration registers
    t_cfg       r_cfg;

    // input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    t_result    w_result;
    t_kind      w_kind;
    logic       w_space;
    logic       w_advance;
    logic       w_load;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_enable     <= CHECK_ENABLE_RST;
            r_cfg.raw_length_limit <= RAW_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CHECK_ENABLE: r_cfg.check_enable     <= i_cfg_data[0];
                CFG_RAW_LIMIT:    r_cfg.raw_length_limit <= i_cfg_data;
                default:          r_cfg                  <= r_cfg;
            endcase
        end
    end

    // Advance the held byte when it gives no result or the output has room.
    assign w_advance = r_in_valid && (!w_result.valid || w_space);
    assign w_load    = w_advance && w_result.valid;
    assign o_ready   = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    // hold the byte until it is decoded
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    efr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    efr_out_reg u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_load),
        .i_result       (w_result),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_space        (w_space),
        .o_result_kind  (w_kind),
        .o_payload_byte (o_payload_byte)
    );

    assign o_result_kind = w_kind;

    // a result never overwrites one that is still waiting
    `EFR_ASSERT_IMPLY(a_load_has_room, i_clk, i_rst_n, w_load, (!o_valid || i_ready))
    // a byte that cannot advance stays in the input register unchanged
    `EFR_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, (r_in_valid && !w_advance), (r_in_valid && (r_in_byte == $past(r_in_byte))))
    // a waiting result that is not taken is still shown next cycle
    `EFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready), (o_valid && (o_payload_byte == $past(o_payload_byte))))

endmodule

// File: rtl/efr_core.sv
// Deframing state and per-byte decode for the escaped frame receiver.
// Depends on efr_pkg for the result and configuration structs.
module efr_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  efr_pkg::t_cfg    i_cfg,
    output efr_pkg::t_result o_result
);
    import efr_pkg::*;

    logic       r_prev_was_flag, n_prev_was_flag;
    logic       r_in_frame,      n_in_frame;
    logic       r_escape,        n_escape;
    logic [8:0] r_raw_count,     n_raw_count;
    logic [7:0] r_held_byte,     n_held_byte;
    logic       r_held_valid,    n_held_valid;
    logic [7:0] r_xor,           n_xor;

    logic [8:0] w_count_inc;
    logic [7:0] w_held_out;
    logic [7:0] w_value;
    logic       w_push;

    always_comb begin
        n_prev_was_flag = r_prev_was_flag;
        n_in_frame      = r_in_frame;
        n_escape        = r_escape;
        n_raw_count     = r_raw_count;
        n_held_byte     = r_held_byte;
        n_held_valid    = r_held_valid;
        n_xor           = r_xor;
        o_result        = '{valid: 1'b0, kind: KIND_PAYLOAD, data: 8'd0};
        w_count_inc     = r_raw_count + 9'd1;
        w_held_out      = r_held_valid ? r_held_byte : 8'd0;
        w_value         = i_byte;
        w_push          = 1'b0;

        if (!r_in_frame) begin
            if (r_prev_was_flag && (i_byte == FLAG_BYTE)) begin
                n_in_frame      = 1'b1;
                n_prev_was_flag = 1'b0;
                n_escape        = 1'b0;
                n_raw_count     = HDR_COUNT;
                n_held_valid    = 1'b0;
                n_held_byte     = 8'd0;
                n_xor           = 8'd0;
            end else begin
                n_prev_was_flag = (i_byte == FLAG_BYTE);
            end
        end else begin
            n_raw_count = w_count_inc;
            if ((w_count_inc > {1'b0, i_cfg.raw_length_limit}) || (i_byte == FLAG_BYTE)) begin
                // drop back to hunting on overflow or close
                n_in_frame      = 1'b0;
                n_prev_was_flag = 1'b0;
                n_escape        = 1'b0;
                n_raw_count     = 9'd0;
                n_held_valid    = 1'b0;
                o_result.valid  = 1'b1;
                o_result.data   = w_held_out;
                if (w_count_inc > {1'b0, i_cfg.raw_length_limit}) begin
                    o_result.kind = KIND_OVERFLOW;
                end else if (r_escape) begin
                    o_result.kind = KIND_DANGLING;
                end else if (!r_held_valid) begin
                    o_result.kind = KIND_EMPTY;
                end else if (i_cfg.check_enable && (r_held_byte != r_xor)) begin
                    o_result.kind = KIND_BCC;
                end else begin
                    o_result.kind = KIND_OK;
                end
            end else if (r_escape) begin
                n_escape = 1'b0;
                w_value  = ESC_BYTE | i_byte;
                w_push   = 1'b1;
            end else if (i_byte == ESC_BYTE) begin
                n_escape = 1'b1;
            end else begin
                w_push = 1'b1;
            end

            if (w_push) begin
                // hold the new byte, release the previous one as payload
                n_held_byte  = w_value;
                n_held_valid = 1'b1;
                if (r_held_valid) begin
                    n_xor          = r_xor ^ r_held_byte;
                    o_result.valid = 1'b1;
                    o_result.kind  = KIND_PAYLOAD;
                    o_result.data  = r_held_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_was_flag <= 1'b0;
            r_in_frame      <= 1'b0;
            r_escape        <= 1'b0;
            r_raw_count     <= 9'd0;
            r_held_byte     <= 8'd0;
            r_held_valid    <= 1'b0;
            r_xor           <= 8'd0;
        end else if (i_step) begin
            r_prev_was_flag <= n_prev_was_flag;
            r_in_frame      <= n_in_frame;
            r_escape        <= n_escape;
            r_raw_count     <= n_raw_count;
            r_held_byte     <= n_held_byte;
            r_held_valid    <= n_held_valid;
            r_xor           <= n_xor;
        end
    end

endmodule

// File: rtl/efr_out_reg.sv
// Result register with valid/ready handshake for the escaped frame receiver.
// Depends on efr_pkg for the result struct.
module efr_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  efr_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_valid,
    output logic             o_space,
    output efr_pkg::t_kind   o_result_kind,
    output logic [7:0]       o_payload_byte
);
    import efr_pkg::*;

    logic       r_valid;
    t_kind      r_kind;
    logic [7:0] r_data;

    assign o_space        = !r_valid || i_ready;
    assign o_valid        = r_valid;
    assign o_result_kind  = r_kind;
    assign o_payload_byte = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind <= i_result.kind;
            r_data <= i_result.data;
        end
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for escaped_frame_receiver_xor_check_unit: a byte-level
// deframer model predicts every status beat, a queue-fed driver and a monitor
// run the handshakes with random gaps. Depends on efr_pkg and the block's RTL.

module tb;
    import efr_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int SETTLE_CYCLES = 4;   // input register plus decode, with margin
    localparam int MAX_WAIT      = 14;
    localparam int MAX_REPORTS   = 10;

    // How a side spaces its beats: never, now and then, or on every beat.
    typedef enum {IDLE_NONE, IDLE_SPARSE, IDLE_FULL} t_idle_mode;

    // How a generated frame is closed.
    typedef enum {
        CLOSE_GOOD_SUM,
        CLOSE_BAD_SUM,
        CLOSE_DANGLING,
        CLOSE_NO_SUM,
        CLOSE_NONE
    } t_frame_close;

    typedef struct {
        t_kind      kind;
        logic [7:0] data;
    } t_deframed;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    logic       o_ready;
    logic [7:0] i_rx_byte      = 8'h00;
    logic       o_valid;
    logic       i_ready        = 1'b0;
    logic [2:0] o_result_kind;
    logic [7:0] o_payload_byte;
    logic       i_cfg_valid    = 1'b0;
    logic       o_cfg_ready;
    logic [0:0] i_cfg_index    = CFG_CHECK_ENABLE;
    logic [7:0] i_cfg_data     = 8'h00;

    // Deframer state as the block should hold it, plus its two registers.
    logic       cfg_check_en;
    logic [7:0] cfg_raw_limit;
    logic       hunt_saw_flag;
    logic       frm_open;
    logic       frm_escape;
    logic [8:0] frm_raw_cnt;
    logic [7:0] frm_held;
    logic       frm_held_v;
    logic [7:0] frm_xor;

    t_deframed   deframed_q[$];     // status and payload beats still owed by the block
    logic [7:0]  line_bytes_q[$];   // raw line bytes not yet handed to the driver
    t_idle_mode  tx_idle    = IDLE_FULL;
    t_idle_mode  rx_idle    = IDLE_FULL;
    int unsigned tx_gap     = 0;
    int unsigned rx_stall   = 0;
    int unsigned err_cnt    = 0;
    int unsigned queued_cnt = 0;

    escaped_frame_receiver_xor_check_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_kind  (o_result_kind),
        .o_payload_byte (o_payload_byte),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Deframer prediction
    // ------------------------------------------------------------------

    task automatic owe_beat(input t_kind kind, input logic [7:0] data);
        t_deframed r;
        r.kind = kind;
        r.data = data;
        deframed_q.push_back(r);
    endtask

    // Drop the frame and hunt again with no 0xFF remembered.
    task automatic return_to_hunt();
        frm_open      = 1'b0;
        hunt_saw_flag = 1'b0;
        frm_escape    = 1'b0;
        frm_raw_cnt   = '0;
        frm_held_v    = 1'b0;
    endtask

    // Advance the deframer by one accepted line byte and note what it owes.
    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] held_out;
        logic [7:0] unesc;
        t_kind      kind;
        if (!frm_open) begin
            if (hunt_saw_flag && b == FLAG_BYTE) begin
                frm_open      = 1'b1;
                hunt_saw_flag = 1'b0;
                frm_escape    = 1'b0;
                frm_raw_cnt   = HDR_COUNT;
                frm_held_v    = 1'b0;
                frm_held      = 8'h00;
                frm_xor       = 8'h00;
            end else begin
                hunt_saw_flag = (b == FLAG_BYTE);
            end
            return;
        end

        // Count first: past the limit even a closing flag is dropped.
        frm_raw_cnt = frm_raw_cnt + 9'd1;
        held_out    = frm_held_v ? frm_held : 8'h00;
        if (frm_raw_cnt > {1'b0, cfg_raw_limit}) begin
            return_to_hunt();
            owe_beat(KIND_OVERFLOW, held_out);
            return;
        end

        if (b == FLAG_BYTE) begin
            // A dangling escape wins over empty and checksum outcomes.
            if (frm_escape)
                kind = KIND_DANGLING;
            else if (!frm_held_v)
                kind = KIND_EMPTY;
            else if (cfg_check_en && frm_held != frm_xor)
                kind = KIND_BCC;
            else
                kind = KIND_OK;
            return_to_hunt();
            owe_beat(kind, held_out);
            return;
        end

        if (frm_escape) begin
            frm_escape = 1'b0;
            unesc      = ESC_BYTE | b;
        end else if (b == ESC_BYTE) begin
            frm_escape = 1'b1;
            return;
        end else begin
            unesc = b;
        end

        // Push the held byte out as payload; the new one takes its place.
        if (frm_held_v) begin
            frm_xor = frm_xor ^ frm_held;
            owe_beat(KIND_PAYLOAD, frm_held);
        end
        frm_held   = unesc;
        frm_held_v = 1'b1;
    endtask

    function automatic int unsigned draw_wait(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:   return 0;
            IDLE_SPARSE: return ($urandom_range(9) == 0) ? $urandom_range(MAX_WAIT, 1) : 0;
            default:     return $urandom_range(MAX_WAIT);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input driver: one line byte per beat, random gap after each beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            // Feed the model with the byte that moved on this edge.
            if (i_valid && o_ready)
                deframe_byte(i_rx_byte);
            // Hold a waiting beat as it is; otherwise idle or launch the next.
            if (!i_valid || o_ready) begin
                if (tx_gap != 0) begin
                    i_valid <= 1'b0;
                    tx_gap  <= tx_gap - 1;
                end else if (line_bytes_q.size() != 0) begin
                    i_valid   <= 1'b1;
                    i_rx_byte <= line_bytes_q.pop_front();
                    tx_gap    <= draw_wait(tx_idle);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each beat with the oldest owed one, then stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_deframed   want;
        int unsigned stall;
        if (!i_rst_n) begin
            i_ready  <= 1'b0;
            rx_stall <= 0;
        end else begin
            stall = rx_stall;
            if (o_valid && i_ready) begin
                if (deframed_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("unexpected beat: kind %0d byte %02h",
                                 o_result_kind, o_payload_byte);
                end else begin
                    want = deframed_q.pop_front();
                    if (o_result_kind !== want.kind || o_payload_byte !== want.data) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display({"beat mismatch: expected kind %0d byte %02h,",
                                      " got kind %0d byte %02h"},
                                     want.kind, want.data, o_result_kind,
                                     o_payload_byte);
                    end
                end
                stall = draw_wait(rx_idle);
            end
            if (stall != 0) begin
                i_ready  <= 1'b0;
                rx_stall <= stall - 1;
            end else begin
                i_ready  <= 1'b1;
                rx_stall <= 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Line traffic generation
    // ------------------------------------------------------------------

    task automatic queue_byte(input logic [7:0] b);
        line_bytes_q.push_back(b);
        queued_cnt++;
    endtask

    // Bias toward the two marker bytes and zero.
    function automatic logic [7:0] line_noise();
        logic [7:0] v;
        v = 8'($urandom);
        case ($urandom_range(9))
            0:       return FLAG_BYTE;
            1:       return ESC_BYTE;
            2:       return 8'h00;
            default: return v;
        endcase
    endfunction

    // Escape the two marker values; any tail with the right low bit decodes back.
    task automatic queue_stuffed(input logic [7:0] v);
        logic [7:0] tail;
        tail = 8'($urandom);
        if (v == FLAG_BYTE) begin
            tail[0] = 1'b1;
            if (tail == FLAG_BYTE)
                tail = 8'h01;
            queue_byte(ESC_BYTE);
            queue_byte(tail);
        end else if (v == ESC_BYTE) begin
            tail[0] = 1'b0;
            queue_byte(ESC_BYTE);
            queue_byte(tail);
        end else begin
            queue_byte(v);
        end
    endtask

    task automatic queue_frame(input int unsigned n_payload, input t_frame_close close_how);
        logic [7:0] v;
        logic [7:0] sum;
        sum = 8'h00;
        queue_byte(FLAG_BYTE);
        queue_byte(FLAG_BYTE);
        for (int i = 0; i < n_payload; i++) begin
            v   = line_noise();
            sum = sum ^ v;
            queue_stuffed(v);
        end
        case (close_how)
            CLOSE_GOOD_SUM: begin
                queue_stuffed(sum);
                queue_byte(FLAG_BYTE);
            end
            CLOSE_BAD_SUM: begin
                queue_stuffed(sum ^ (8'h01 << $urandom_range(7)));
                queue_byte(FLAG_BYTE);
            end
            CLOSE_DANGLING: begin
                queue_stuffed(sum);
                queue_byte(ESC_BYTE);
                queue_byte(FLAG_BYTE);
            end
            CLOSE_NO_SUM: queue_byte(FLAG_BYTE);
            default: ;  // leave the frame open
        endcase
    endtask

    // Mostly well-formed frames of random content, some broken ones and noise.
    task automatic queue_random_traffic(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned len;
        stop_at = queued_cnt + n_items;
        while (queued_cnt < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 2)
                len = $urandom_range(300, 240);
            else if (pick < 30)
                len = $urandom_range(24, 7);
            else
                len = $urandom_range(6);
            pick = $urandom_range(99);
            if (pick < 55)
                queue_frame(len, CLOSE_GOOD_SUM);
            else if (pick < 70)
                queue_frame(len, CLOSE_BAD_SUM);
            else if (pick < 76)
                queue_frame(len, CLOSE_DANGLING);
            else if (pick < 83)
                queue_frame(len, CLOSE_NO_SUM);
            else if (pick < 88)
                queue_frame(len, CLOSE_NONE);
            else if (pick < 91) begin
                // Three flags in a row: opens on the second, closes empty on the third.
                queue_byte(FLAG_BYTE);
                queue_frame(len, CLOSE_GOOD_SUM);
            end else begin
                repeat ($urandom_range(6, 1))
                    queue_byte(line_noise());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Register writes and phase control
    // ------------------------------------------------------------------

    // Wait for every byte to go in and every owed beat to come out, then
    // let a byte with no result clear the decode stage.
    task automatic wait_for_drain();
        while (line_bytes_q.size() != 0 || i_valid || deframed_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [7:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready)
                break;
        end
        i_cfg_valid <= 1'b0;
        if (idx == CFG_CHECK_ENABLE)
            cfg_check_en = data[0];
        else
            cfg_raw_limit = data;
    endtask

    task automatic run_phase(input logic check_en, input logic [7:0] raw_limit,
                             input t_idle_mode tx_mode, input t_idle_mode rx_mode,
                             input int unsigned n_items);
        logic [7:0] en_word;
        wait_for_drain();
        // Upper bits of the enable word are don't-care; drive them at random.
        en_word    = 8'($urandom);
        en_word[0] = check_en;
        write_reg(CFG_CHECK_ENABLE, en_word);
        write_reg(CFG_RAW_LIMIT, raw_limit);
        tx_idle = tx_mode;
        rx_idle = rx_mode;
        queue_random_traffic(n_items);
        // Leave a frame open so the next register write lands mid-frame.
        queue_frame($urandom_range(3), CLOSE_NONE);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] opening [25];
        cfg_check_en  = CHECK_ENABLE_RST;
        cfg_raw_limit = RAW_LIMIT_RST;
        hunt_saw_flag = 1'b0;
        frm_open      = 1'b0;
        frm_escape    = 1'b0;
        frm_raw_cnt   = '0;
        frm_held      = 8'h00;
        frm_held_v    = 1'b0;
        frm_xor       = 8'h00;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty frame from three flags, dangling escape, checksum-only frame,
        // escaped marker payload with good sum, and a checksum error.
        opening = '{FLAG_BYTE, FLAG_BYTE, FLAG_BYTE,
                    FLAG_BYTE, FLAG_BYTE, ESC_BYTE, FLAG_BYTE,
                    FLAG_BYTE, FLAG_BYTE, 8'h00, FLAG_BYTE,
                    FLAG_BYTE, FLAG_BYTE, ESC_BYTE, 8'h00, ESC_BYTE, 8'h01, 8'h01, FLAG_BYTE,
                    FLAG_BYTE, FLAG_BYTE, 8'h7F, 8'h80, 8'h55, FLAG_BYTE};
        foreach (opening[i])
            queue_byte(opening[i]);

        run_phase(1'b1, RAW_LIMIT_RST, IDLE_FULL,   IDLE_FULL,   300);
        run_phase(1'b0, 8'd4,          IDLE_FULL,   IDLE_NONE,   200);
        run_phase(1'b1, 8'd20,         IDLE_NONE,   IDLE_NONE,   250);
        run_phase(1'b0, 8'd255,        IDLE_SPARSE, IDLE_FULL,   300);
        run_phase(1'b1, 8'd2,          IDLE_FULL,   IDLE_SPARSE, 100);
        run_phase(1'b0, 8'd0,          IDLE_SPARSE, IDLE_NONE,    60);
        run_phase(1'b1, 8'd137,        IDLE_SPARSE, IDLE_SPARSE, 340);
        wait_for_drain();

        if (err_cnt == 0)
            $display("[escaped_frame_receiver_xor_check_unit] OK");
        else
            $display("[escaped_frame_receiver_xor_check_unit] ERROR");
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin : watchdog
        #(10_000_000);
        $display("[escaped_frame_receiver_xor_check_unit] ERROR");
        $finish;
    end

endmodule
